// ----- src/vcs_pkg.sv -----
// Shared constants, types and structs of the vertex cache soft cluster splitter.
package vcs_pkg;

	localparam int VERTEX_TOTAL      = 65536;
	localparam int MAX_SEGMENT_FACES = 1048576;

	localparam int VIDX_W     = 16;
	localparam int CACHE_W    = 13;
	localparam int THR_W      = 18;
	localparam int FACE_W     = 21;
	localparam int MISS_W     = 22;
	localparam int FM_W       = 2;
	localparam int STAMP_W    = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;

	localparam int MEM_DEPTH = (VERTEX_TOTAL < (1 << VIDX_W)) ? VERTEX_TOTAL : (1 << VIDX_W);
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam int MISS_LIMIT = 3 * MAX_SEGMENT_FACES;
	localparam int FCNT_W     = $clog2(MAX_SEGMENT_FACES + 1);
	localparam int MCNT_W     = $clog2(MISS_LIMIT + 1);
	localparam int PROD_W     = THR_W + FCNT_W;
	localparam int LHS_W      = MCNT_W + 16;
	localparam int CMP_W      = (PROD_W > LHS_W) ? PROD_W : LHS_W;

	localparam int RES_DEPTH = 2;
	localparam int PEND_W    = $clog2(RES_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_A,
		ST_B,
		ST_C
	} issue_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CACHE_DEPTH,
		REG_MISS_THR
	} cfg_reg_t;

	typedef struct packed {
		logic               probe;
		logic               first;
		logic               last;
		logic               hard;
		logic [VIDX_W-1:0]  vidx;
		logic               clr;
		logic [ADDR_W-1:0]  clr_addr;
	} mem_req_t;

	typedef struct packed {
		logic [CACHE_W-1:0] cache_depth;
		logic [THR_W-1:0]   miss_thr;
	} cfg_regs_t;

	typedef struct packed {
		logic              new_segment;
		logic [FM_W-1:0]   face_misses;
		logic [MISS_W-1:0] segment_misses;
		logic [FACE_W-1:0] segment_faces;
		logic              segment_closes;
	} res_t;

endpackage

// ----- src/vcs_ifs.sv -----
// Channel interfaces: triangle requests, result requests and register writes.
interface vcs_tri_if import vcs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VIDX_W-1:0] vertex_a;
	logic [VIDX_W-1:0] vertex_b;
	logic [VIDX_W-1:0] vertex_c;
	logic              hard_start;

	modport source (output valid, vertex_a, vertex_b, vertex_c, hard_start, input ready);
	modport sink (input valid, vertex_a, vertex_b, vertex_c, hard_start, output ready);
endinterface

interface vcs_res_if import vcs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              new_segment;
	logic [FM_W-1:0]   face_misses;
	logic [MISS_W-1:0] segment_misses;
	logic [FACE_W-1:0] segment_faces;
	logic              segment_closes;

	modport source (output valid, new_segment, face_misses, segment_misses, segment_faces,
		segment_closes, input ready);
	modport sink (input valid, new_segment, face_misses, segment_misses, segment_faces,
		segment_closes, output ready);
endinterface

interface vcs_cfg_if import vcs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/vertex_cache_soft_cluster_splitter.sv -----
// Flow: an accepted triangle is buffered and its vertices a, b and c are probed in turn, one stamp
// RAM read each (a write on a miss); the next triangle is taken while vertex c is issued.
// The 2-entry result queue lets the next triangle start while a result waits.
// Reset: counters, stamp and segment state clear at once; the stamp RAM is then
// swept to zero, all 65536 entries, while triangle ready stays low.
// Register defaults after reset: cache depth 16, miss-per-face threshold 0.
module vertex_cache_soft_cluster_splitter import vcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	vcs_tri_if.sink   triangle,
	vcs_res_if.source result,
	vcs_cfg_if.sink   cfg
);

	cfg_regs_t cfg_q;
	mem_req_t  req;
	res_t      res;
	logic      res_push;
	logic      res_pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cache_depth <= CACHE_W'(16);
			cfg_q.miss_thr    <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_CACHE_DEPTH: cfg_q.cache_depth <= cfg.data[CACHE_W-1:0];
				REG_MISS_THR:    cfg_q.miss_thr    <= cfg.data[THR_W-1:0];
			endcase
		end
	end

	vcs_issue u_issue (
		.clk      (clk),
		.arst_n   (arst_n),
		.triangle (triangle),
		.res_pop  (res_pop),
		.req      (req)
	);

	vcs_probe u_probe (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_regs (cfg_q),
		.res_push (res_push),
		.res      (res)
	);

	vcs_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.result (result),
		.pop    (res_pop)
	);

endmodule

// ----- src/vcs_issue.sv -----
// Triangle input buffer, stamp RAM clear sweep and per-vertex read sequencer.
module vcs_issue import vcs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	vcs_tri_if.sink  triangle,
	input  logic     res_pop,
	output mem_req_t req
);

	issue_state_t      state_q, state_d;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [PEND_W-1:0] pend_q;
	logic              item_v_q;
	logic [VIDX_W-1:0] a_q, b_q, c_q;
	logic              hard_q;
	logic              start;
	logic              accept;
	logic              clr_done;

	assign clr_done = (clr_addr_q == ADDR_W'(MEM_DEPTH - 1));
	assign start    = item_v_q && ((pend_q != PEND_W'(RES_DEPTH)) || res_pop);
	assign accept   = triangle.valid && triangle.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_done)
					state_d = ST_A;
			end
			ST_A: begin
				if (start)
					state_d = ST_B;
			end
			ST_B: state_d = ST_C;
			ST_C: state_d = ST_A;
		endcase
	end

	always_comb begin
		req            = '0;
		req.clr_addr   = clr_addr_q;
		req.hard       = hard_q;
		req.vidx       = a_q;
		triangle.ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				req.clr = 1'b1;
			end
			ST_A: begin
				req.probe      = start;
				req.first      = 1'b1;
				triangle.ready = !item_v_q;
			end
			ST_B: begin
				req.probe = 1'b1;
				req.vidx  = b_q;
			end
			ST_C: begin
				req.probe      = 1'b1;
				req.last       = 1'b1;
				req.vidx       = c_q;
				triangle.ready = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			pend_q     <= '0;
			item_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			pend_q <= pend_q + PEND_W'(state_q == ST_A && start) - PEND_W'(res_pop);
			if (accept)
				item_v_q <= 1'b1;
			else if (state_q == ST_C)
				item_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= triangle.vertex_a;
			b_q    <= triangle.vertex_b;
			c_q    <= triangle.vertex_c;
			hard_q <= triangle.hard_start;
		end
	end

endmodule

// ----- src/vcs_probe.sv -----
// Timestamp RAM with read-modify-write probe stage, segment counters and close test.
module vcs_probe import vcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mem_req_t  req,
	input  cfg_regs_t cfg_regs,
	output logic      res_push,
	output res_t      res
);

	logic [STAMP_W-1:0] mem [MEM_DEPTH];

	logic               v_s1, first_s1, last_s1, hard_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               inrange_s1;
	logic [STAMP_W-1:0] rdata_s1;

	logic               wr_v_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [STAMP_W-1:0] wr_data_q;

	logic [STAMP_W-1:0] cur_stamp_q;
	logic               seg_open_q;
	logic [MCNT_W-1:0]  miss_q;
	logic [FCNT_W-1:0]  face_q;
	logic [FM_W-1:0]    fm_q;
	logic               starts_q;
	logic [PROD_W-1:0]  prod_q;

	logic               starts, jump, miss, wr_en, closes, mid;
	logic [STAMP_W-1:0] stamp_base, stored, age;
	logic [MCNT_W-1:0]  miss_base, miss_next;
	logic [FM_W-1:0]    fm_next;
	logic [FCNT_W-1:0]  face_next;
	logic [ADDR_W-1:0]  req_addr;

	assign req_addr = req.vidx[ADDR_W-1:0];

	always_comb begin
		starts     = hard_s1 || !seg_open_q;
		jump       = first_s1 && starts;
		mid        = v_s1 && !first_s1 && !last_s1;
		stamp_base = cur_stamp_q + (jump ? (STAMP_W'(cfg_regs.cache_depth) + STAMP_W'(1))
			: '0);
		// same-entry write landed on the edge that launched this read
		stored     = (wr_v_q && wr_addr_q == addr_s1) ? wr_data_q : rdata_s1;
		age        = stamp_base - stored;
		miss       = v_s1 && (!inrange_s1 || age > STAMP_W'(cfg_regs.cache_depth));
		wr_en      = miss && inrange_s1;
		miss_base  = jump ? '0 : miss_q;
		miss_next  = (miss && miss_base != MCNT_W'(MISS_LIMIT)) ? miss_base + MCNT_W'(1)
			: miss_base;
		fm_next    = (first_s1 ? '0 : fm_q) + FM_W'(miss);
		if (starts)
			face_next = FCNT_W'(1);
		else if (face_q != FCNT_W'(MAX_SEGMENT_FACES))
			face_next = face_q + FCNT_W'(1);
		else
			face_next = face_q;
		closes = ((CMP_W'(miss_next)) << 16) <= CMP_W'(prod_q);
	end

	assign res_push           = v_s1 && last_s1;
	assign res.new_segment    = starts_q;
	assign res.face_misses    = fm_next;
	assign res.segment_misses = MISS_W'(miss_next);
	assign res.segment_faces  = FACE_W'(face_q);
	assign res.segment_closes = closes;

	always_ff @(posedge clk) begin
		if (req.clr)
			mem[req.clr_addr] <= '0;
		else if (wr_en)
			mem[addr_s1] <= stamp_base;
		if (req.probe)
			rdata_s1 <= mem[req_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			wr_v_q      <= 1'b0;
			cur_stamp_q <= '0;
			seg_open_q  <= 1'b0;
			miss_q      <= '0;
			face_q      <= '0;
			fm_q        <= '0;
			starts_q    <= 1'b0;
		end else begin
			v_s1     <= req.probe;
			first_s1 <= req.first;
			last_s1  <= req.last;
			wr_v_q   <= wr_en;
			if (v_s1) begin
				cur_stamp_q <= stamp_base + STAMP_W'(miss);
				miss_q      <= miss_next;
				fm_q        <= fm_next;
			end
			if (v_s1 && first_s1) begin
				face_q   <= face_next;
				starts_q <= starts;
			end
			if (v_s1 && last_s1)
				seg_open_q <= !closes;
		end
	end

	always_ff @(posedge clk) begin
		hard_s1    <= req.hard;
		addr_s1    <= req_addr;
		inrange_s1 <= (32'(req.vidx) < 32'(VERTEX_TOTAL));
		wr_addr_q  <= addr_s1;
		wr_data_q  <= stamp_base;
		if (mid)
			prod_q <= PROD_W'(cfg_regs.miss_thr) * PROD_W'(face_q);
	end

endmodule

// ----- src/vcs_res_fifo.sv -----
// Two-entry result queue driving the result channel.
module vcs_res_fifo import vcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_t      din,
	vcs_res_if.source result,
	output logic      pop
);

	res_t              ent_q [RES_DEPTH];
	logic              wr_ptr_q, rd_ptr_q;
	logic [PEND_W-1:0] cnt_q;
	res_t              head;

	assign head                  = ent_q[rd_ptr_q];
	assign result.valid          = (cnt_q != '0);
	assign result.new_segment    = head.new_segment;
	assign result.face_misses    = head.face_misses;
	assign result.segment_misses = head.segment_misses;
	assign result.segment_faces  = head.segment_faces;
	assign result.segment_closes = head.segment_closes;
	assign pop                   = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + PEND_W'(push) - PEND_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= din;
	end

endmodule
